// ===== rtl/basm_pkg.sv =====
// ----------------------------------------------------------------------------
// basm_pkg: shared definitions of the border array string matcher
// Command codes, decoded operations and the word passed from front to engine.
// ----------------------------------------------------------------------------
package basm_pkg;

  localparam int DEF_MAX_PATTERN = 256;
  localparam int DEF_SYMBOL_BITS = 8;
  localparam int SYM_FIELD_W     = 8;
  localparam int CMD_W           = 2;
  localparam int POS_W           = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TEXT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [SYM_FIELD_W-1:0] sym;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } eng_state_t;

endpackage

// ===== rtl/basm_in_if.sv =====
// ----------------------------------------------------------------------------
// basm_in_if: input channel
// Carries one command word with its symbol under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface basm_in_if;
  logic                             valid;
  logic                             ready;
  logic [basm_pkg::CMD_W-1:0]       command;
  logic [basm_pkg::SYM_FIELD_W-1:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

// ===== rtl/basm_out_if.sv =====
// ----------------------------------------------------------------------------
// basm_out_if: result channel
// Carries one result word per command under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface basm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       match_found;
  logic [basm_pkg::POS_W-1:0] match_start;
  logic                       pattern_overflow;

  modport source (output valid, output match_found, output match_start,
                  output pattern_overflow, input ready);
  modport sink   (input valid, input match_found, input match_start,
                  input pattern_overflow, output ready);
endinterface

// ===== rtl/basm_ram.sv =====
// ----------------------------------------------------------------------------
// basm_ram: generic single write, single read memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module basm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/basm_front.sv =====
// ----------------------------------------------------------------------------
// basm_front: input acceptance and classification
// Decodes each input word into an operation and holds it in a short queue.
// ----------------------------------------------------------------------------
module basm_front (
  input  logic            clk,
  input  logic            rst,
  basm_in_if.sink         item,
  output basm_pkg::cmd_t  q_word,
  output logic            q_valid,
  input  logic            q_pop
);
  import basm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  cmd_t          decoded;

  always_comb begin
    decoded.sym = item.symbol;
    case (item.command)
      CMD_CLEAR:  decoded.op = OP_CLEAR;
      CMD_APPEND: decoded.op = OP_APPEND;
      CMD_TEXT:   decoded.op = OP_TEXT;
      default:    decoded.op = OP_NONE;
    endcase
  end

  assign item.ready = (count != CW'(QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != '0);
  assign q_word     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/basm_engine.sv =====
// ----------------------------------------------------------------------------
// basm_engine: pattern build and text walk
// Runs the border fallback walk over the pattern and border memories and
// drives the result register.
// ----------------------------------------------------------------------------
module basm_engine #(
  parameter int MAX_PATTERN = basm_pkg::DEF_MAX_PATTERN,
  parameter int SYMBOL_BITS = basm_pkg::DEF_SYMBOL_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  basm_pkg::cmd_t  q_word,
  input  logic            q_valid,
  output logic            q_pop,
  basm_out_if.source      result
);
  import basm_pkg::*;

  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;

  eng_state_t       state;
  eng_state_t       state_next;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [LEN_W-1:0] cb;
  logic [LEN_W-1:0] cb_next;
  logic [POS_W-1:0] tp;
  logic [POS_W-1:0] tp_next;
  logic [IDX_W-1:0] last_border;
  logic [IDX_W-1:0] last_border_next;
  logic [IDX_W-1:0] b;
  logic [IDX_W-1:0] b_next;
  op_t              cur_op;
  logic [SYM_W-1:0] cur_sym;
  logic             take;

  logic             rd_en;
  logic [IDX_W-1:0] rd_b;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [SYM_W-1:0] p_wdata;
  logic [IDX_W-1:0] b_wdata;
  logic [SYM_W-1:0] p_rdata;
  logic [IDX_W-1:0] b_rdata;

  logic             res_free;
  logic             res_load;
  logic             res_found;
  logic [POS_W-1:0] res_start;
  logic             res_overflow;

  logic [SYM_W-1:0] head_sym;
  logic             hit;
  logic [LEN_W-1:0] nb;

  basm_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (p_wdata),
    .re    (rd_en),
    .raddr (rd_b),
    .rdata (p_rdata)
  );

  basm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_border_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (b_wdata),
    .re    (rd_en),
    .raddr (rd_b - 1'b1),
    .rdata (b_rdata)
  );

  assign res_free = !result.valid || result.ready;
  assign head_sym = q_word.sym[SYM_W-1:0];
  assign hit      = (p_rdata == cur_sym);
  assign nb       = hit ? LEN_W'(b) + 1'b1 : '0;

  always_comb begin
    state_next       = state;
    len_next         = len;
    cb_next          = cb;
    tp_next          = tp;
    last_border_next = last_border;
    b_next           = b;
    take             = 1'b0;
    q_pop            = 1'b0;
    rd_en            = 1'b0;
    rd_b             = b;
    wr_en            = 1'b0;
    wr_addr          = len[IDX_W-1:0];
    p_wdata          = cur_sym;
    b_wdata          = nb[IDX_W-1:0];
    res_load         = 1'b0;
    res_found        = 1'b0;
    res_start        = '0;
    res_overflow     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_word.op)
            OP_CLEAR: begin
              if (res_free) begin
                q_pop    = 1'b1;
                res_load = 1'b1;
                len_next = '0;
                cb_next  = '0;
                tp_next  = '0;
              end
            end
            OP_APPEND: begin
              if (len == LEN_W'(MAX_PATTERN)) begin
                if (res_free) begin
                  q_pop        = 1'b1;
                  res_load     = 1'b1;
                  res_overflow = 1'b1;
                end
              end else if (len == '0) begin
                if (res_free) begin
                  q_pop            = 1'b1;
                  res_load         = 1'b1;
                  wr_en            = 1'b1;
                  wr_addr          = '0;
                  p_wdata          = head_sym;
                  b_wdata          = '0;
                  last_border_next = '0;
                  len_next         = LEN_W'(1);
                  cb_next          = '0;
                  tp_next          = '0;
                end
              end else begin
                q_pop      = 1'b1;
                take       = 1'b1;
                rd_en      = 1'b1;
                rd_b       = last_border;
                b_next     = last_border;
                state_next = ST_CMP;
              end
            end
            OP_TEXT: begin
              if (len == '0) begin
                if (res_free) begin
                  q_pop    = 1'b1;
                  res_load = 1'b1;
                  tp_next  = tp + 1'b1;
                end
              end else begin
                q_pop      = 1'b1;
                take       = 1'b1;
                rd_en      = 1'b1;
                rd_b       = (cb >= len) ? last_border : cb[IDX_W-1:0];
                b_next     = rd_b;
                state_next = ST_CMP;
              end
            end
            default: begin
              if (res_free) begin
                q_pop    = 1'b1;
                res_load = 1'b1;
              end
            end
          endcase
        end
      end
      ST_CMP: begin
        if (!hit && (b != '0)) begin
          rd_en  = 1'b1;
          rd_b   = b_rdata;
          b_next = b_rdata;
        end else if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
          if (cur_op == OP_APPEND) begin
            wr_en            = 1'b1;
            last_border_next = nb[IDX_W-1:0];
            len_next         = len + 1'b1;
            cb_next          = '0;
            tp_next          = '0;
          end else begin
            cb_next = nb;
            tp_next = tp + 1'b1;
            if (nb == len) begin
              res_found = 1'b1;
              res_start = tp - POS_W'(len) + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      len         <= '0;
      cb          <= '0;
      tp          <= '0;
      last_border <= '0;
    end else begin
      state       <= state_next;
      len         <= len_next;
      cb          <= cb_next;
      tp          <= tp_next;
      last_border <= last_border_next;
    end
  end

  always_ff @(posedge clk) begin
    b <= b_next;
    if (take) begin
      cur_op  <= q_word.op;
      cur_sym <= head_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.match_found      <= res_found;
      result.match_start      <= res_start;
      result.pattern_overflow <= res_overflow;
    end
  end

endmodule

// ===== rtl/border_array_string_matcher_top.sv =====
// ----------------------------------------------------------------------------
// border_array_string_matcher_top: exact pattern matcher, border array form
//
//   Channel  Direction  Word contents
//   item     in         command, symbol
//   result   out        match_found, match_start, pattern_overflow
//
// Clear, the first append of a pattern, overflowing appends, text on an empty
// pattern and unused commands are answered from the idle state. Other appends
// and text symbols go through the compare state, which reads the pattern and
// border RAMs once more per border fallback; the RAMs have a registered read.
// Synchronous reset clears lengths, positions and handshakes; the stores need
// no clearing pass. A two-word queue lets the front accept while the engine
// walks; a finished word waits in the engine until the result register is free.
// ----------------------------------------------------------------------------
module border_array_string_matcher_top #(
  parameter int MAX_PATTERN = basm_pkg::DEF_MAX_PATTERN,
  parameter int SYMBOL_BITS = basm_pkg::DEF_SYMBOL_BITS
) (
  input  logic       clk,
  input  logic       rst,
  basm_in_if.sink    item,
  basm_out_if.source result
);
  import basm_pkg::*;

  cmd_t q_word;
  logic q_valid;
  logic q_pop;

  basm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_word  (q_word),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  basm_engine #(
    .MAX_PATTERN (MAX_PATTERN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_word  (q_word),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .result  (result)
  );

`ifndef SYNTHESIS
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> q_valid)
    else $error("Accepted word did not reach the queue.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("Engine popped an empty queue.");

  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> q_valid)
    else $error("Queue refuses words while empty.");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.match_found |-> !result.pattern_overflow)
    else $error("Match and overflow reported in one word.");
`endif

endmodule
